>>> hdl/bis_pkg.sv
// Package for the bilinear image scaler: sizes, codes and channel payload types.
package bis_pkg;

    localparam int unsigned SRC_MAX_WIDTH  = 320;
    localparam int unsigned SRC_MAX_HEIGHT = 240;
    localparam int unsigned DST_MAX        = 512;
    localparam int unsigned FRAMES         = 2;

    localparam int unsigned FRAME_SIZE = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
    localparam int unsigned STORE_SIZE = FRAMES * FRAME_SIZE;
    localparam int unsigned ADDR_W     = $clog2(STORE_SIZE);
    localparam int unsigned ROW_W      = $clog2(SRC_MAX_HEIGHT);
    localparam int unsigned COL_W      = $clog2(SRC_MAX_WIDTH);
    localparam int unsigned HDIM_W     = $clog2(SRC_MAX_HEIGHT + 1);
    localparam int unsigned WDIM_W     = $clog2(SRC_MAX_WIDTH + 1);

    localparam int unsigned SADDR_W    = 17;
    localparam int unsigned PIX_W      = 16;
    localparam int unsigned DEST_W     = 9;
    localparam int unsigned OUTC_W     = 10;
    localparam int unsigned CH_W       = 10;
    localparam int unsigned STEP_W     = 24;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned WGT_W      = 8;
    localparam int unsigned POS_W      = DEST_W + STEP_W;
    localparam int unsigned TOP_W      = 18;
    localparam int unsigned SUM_W      = 26;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_H_W    = 8;
    localparam int unsigned CFG_W_W    = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP   = 2'd3;

    localparam logic [CFG_H_W-1:0] RST_SOURCE_HEIGHT = 8'd240;
    localparam logic [CFG_W_W-1:0] RST_SOURCE_WIDTH  = 9'd320;
    localparam logic [STEP_W-1:0]  RST_ROW_STEP      = 24'd60494;
    localparam logic [STEP_W-1:0]  RST_COLUMN_STEP   = 24'd80660;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic               kind;
        logic               frame;
        logic [SADDR_W-1:0] source_address;
        logic [PIX_W-1:0]   source_pixel;
        logic [DEST_W-1:0]  dest_row;
        logic [DEST_W-1:0]  dest_column;
    } t_in_item;

    typedef struct packed {
        logic [OUTC_W-1:0] out_row;
        logic [OUTC_W-1:0] out_column;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
    } t_out_item;

endpackage

>>> hdl/bilinear_image_scaler.sv
// Bilinear image scaler: frame store, neighbor fetch sequencer and interpolation pipeline.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries two kinds of transfer.
// A load writes one RGB565 pixel into one of the stored source frames; it gives no result.
// A request names a frame and a destination row and column and gives one result transfer
// on the output channel (o_out_valid / i_out_stall / o_out_data) with the padded
// coordinates and the interpolated red, green and blue values on a 10-bit scale.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the used source size and
// the Q8.16 row and column steps; write it only while the block is idle.
// A request occupies the single port of the frame memory for its four neighbor reads, one
// neighbor read per cycle unless the tail stage is held; a load takes one write.
// A request then passes the tail register, the weight stage and the output register.
// Requests and loads are served in order, so a request sees every earlier load.
// When the receiver stalls, the result holds on the output register, the pipeline fills
// behind it and o_in_stall rises once no stage is free.
// Reset clears the pipeline and restores the register defaults; the frame memory is
// not cleared and holds undefined data until loaded.
module bilinear_image_scaler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bis_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bis_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef struct packed {
        logic                            kind;
        logic [bis_pkg::ADDR_W-1:0]      addr;
        logic [bis_pkg::PIX_W-1:0]       pixel;
        logic [bis_pkg::OUTC_W-1:0]      out_row;
        logic [bis_pkg::OUTC_W-1:0]      out_column;
        logic [bis_pkg::POS_W-1:0]       prod_r;
        logic [bis_pkg::POS_W-1:0]       prod_c;
    } t_s1;

    typedef struct packed {
        logic                            kind;
        logic [bis_pkg::ADDR_W-1:0]      addr;
        logic [bis_pkg::PIX_W-1:0]       pixel;
        logic [bis_pkg::OUTC_W-1:0]      out_row;
        logic [bis_pkg::OUTC_W-1:0]      out_column;
        logic [bis_pkg::ROW_W-1:0]       r0;
        logic [bis_pkg::ROW_W-1:0]       r1;
        logic [bis_pkg::COL_W-1:0]       c0;
        logic [bis_pkg::COL_W-1:0]       c1;
        logic [bis_pkg::WGT_W-1:0]       fv;
        logic [bis_pkg::WGT_W-1:0]       fu;
    } t_s2;

    typedef struct packed {
        logic [bis_pkg::OUTC_W-1:0]      out_row;
        logic [bis_pkg::OUTC_W-1:0]      out_column;
        logic [bis_pkg::WGT_W-1:0]       fv;
        logic [bis_pkg::WGT_W-1:0]       fu;
        logic [bis_pkg::PIX_W-1:0]       px0;
        logic [bis_pkg::PIX_W-1:0]       px1;
        logic [bis_pkg::PIX_W-1:0]       px2;
    } t_st;

    typedef struct packed {
        logic [bis_pkg::OUTC_W-1:0]            out_row;
        logic [bis_pkg::OUTC_W-1:0]            out_column;
        logic [bis_pkg::WGT_W-1:0]             fv;
        logic [2:0][bis_pkg::TOP_W-1:0]        top;
        logic [2:0][bis_pkg::TOP_W-1:0]        bot;
    } t_sm;

    function automatic logic [bis_pkg::CH_W-1:0] widen(
        input logic [bis_pkg::PIX_W-1:0] px,
        input int                        ch
    );
        logic [bis_pkg::CH_W-1:0] v;
        case (ch)
            bis_pkg::CH_RED:   v = {px[15:11], 5'b0};
            bis_pkg::CH_GREEN: v = {px[10:5], 4'b0};
            bis_pkg::CH_BLUE:  v = {px[4:0], 5'b0};
            default:           v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [bis_pkg::TOP_W-1:0] lerp_h(
        input logic [bis_pkg::WGT_W-1:0] f,
        input logic [bis_pkg::CH_W-1:0]  a,
        input logic [bis_pkg::CH_W-1:0]  b
    );
        logic [bis_pkg::WGT_W:0]   wa;
        logic [bis_pkg::TOP_W-1:0] xa;
        logic [bis_pkg::TOP_W-1:0] xb;
        logic [bis_pkg::TOP_W-1:0] pa;
        logic [bis_pkg::TOP_W-1:0] pb;
        wa = 9'd256 - {1'b0, f};
        xa = bis_pkg::TOP_W'(wa);
        xb = bis_pkg::TOP_W'(f);
        pa = bis_pkg::TOP_W'(a);
        pb = bis_pkg::TOP_W'(b);
        return xa * pa + xb * pb;
    endfunction

    function automatic logic [bis_pkg::CH_W-1:0] lerp_v(
        input logic [bis_pkg::WGT_W-1:0] f,
        input logic [bis_pkg::TOP_W-1:0] a,
        input logic [bis_pkg::TOP_W-1:0] b
    );
        logic [bis_pkg::WGT_W:0]   wa;
        logic [bis_pkg::SUM_W-1:0] xa;
        logic [bis_pkg::SUM_W-1:0] xb;
        logic [bis_pkg::SUM_W-1:0] pa;
        logic [bis_pkg::SUM_W-1:0] pb;
        logic [bis_pkg::SUM_W-1:0] s;
        wa = 9'd256 - {1'b0, f};
        xa = bis_pkg::SUM_W'(wa);
        xb = bis_pkg::SUM_W'(f);
        pa = bis_pkg::SUM_W'(a);
        pb = bis_pkg::SUM_W'(b);
        s  = xa * pa + xb * pb + bis_pkg::SUM_W'(32768);
        return s[bis_pkg::SUM_W-1 -: bis_pkg::CH_W];
    endfunction

    logic [bis_pkg::CFG_H_W-1:0] r_cfg_height;
    logic [bis_pkg::CFG_W_W-1:0] r_cfg_width;
    logic [bis_pkg::STEP_W-1:0]  r_row_step;
    logic [bis_pkg::STEP_W-1:0]  r_col_step;

    logic [bis_pkg::PIX_W-1:0]   r_store [bis_pkg::STORE_SIZE];
    logic [bis_pkg::PIX_W-1:0]   r_mem_q;

    logic                        r_p1_vld;
    t_s1                         r_p1;
    t_s1                         n_p1;
    logic                        r_p2_vld;
    t_s2                         r_p2;
    t_s2                         n_p2;
    logic                        r_p3_vld;
    t_s2                         r_p3;
    logic [1:0]                  r_k;
    logic [bis_pkg::PIX_W-1:0]   r_px0;
    logic [bis_pkg::PIX_W-1:0]   r_px1;
    logic                        r_t_vld;
    t_st                         r_t;
    logic                        r_m1_vld;
    t_sm                         r_m1;
    t_sm                         n_m1;
    logic                        r_out_vld;
    bis_pkg::t_out_item          r_out;
    bis_pkg::t_out_item          n_out;

    logic                        in_acc;
    logic                        in_ok;
    logic                        p1_ready;
    logic                        p2_ready;
    logic                        p3_ready;
    logic                        m1_ready;
    logic                        out_ready;
    logic                        t_go;
    logic                        mem_ok;
    logic                        mem_we;
    logic                        mem_rd;
    logic                        p3_done;
    logic                        t_load;
    logic [bis_pkg::ADDR_W-1:0]  mem_addr;
    logic [bis_pkg::ROW_W-1:0]   rd_row;
    logic [bis_pkg::COL_W-1:0]   rd_col;

    logic [bis_pkg::HDIM_W-1:0]  h_used;
    logic [bis_pkg::WDIM_W-1:0]  w_used;
    logic [bis_pkg::HDIM_W-1:0]  h_last;
    logic [bis_pkg::WDIM_W-1:0]  w_last;
    logic [bis_pkg::POS_W-1:0]   lim_r;
    logic [bis_pkg::POS_W-1:0]   lim_c;
    logic [bis_pkg::POS_W-1:0]   pos_r;
    logic [bis_pkg::POS_W-1:0]   pos_c;
    logic [bis_pkg::ROW_W:0]     r0_inc;
    logic [bis_pkg::COL_W:0]     c0_inc;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_height <= bis_pkg::RST_SOURCE_HEIGHT;
            r_cfg_width  <= bis_pkg::RST_SOURCE_WIDTH;
            r_row_step   <= bis_pkg::RST_ROW_STEP;
            r_col_step   <= bis_pkg::RST_COLUMN_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bis_pkg::REG_SOURCE_HEIGHT: r_cfg_height <= i_cfg_data[bis_pkg::CFG_H_W-1:0];
                bis_pkg::REG_SOURCE_WIDTH:  r_cfg_width  <= i_cfg_data[bis_pkg::CFG_W_W-1:0];
                bis_pkg::REG_ROW_STEP:      r_row_step   <= i_cfg_data[bis_pkg::STEP_W-1:0];
                bis_pkg::REG_COLUMN_STEP:   r_col_step   <= i_cfg_data[bis_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake chain
    assign out_ready = !r_out_vld || !i_out_stall;
    assign m1_ready  = !r_m1_vld || out_ready;
    assign t_go      = r_t_vld && m1_ready;
    assign mem_ok    = !r_t_vld || t_go;
    assign mem_we    = r_p3_vld && (r_p3.kind == bis_pkg::KIND_LOAD);
    assign mem_rd    = r_p3_vld && (r_p3.kind == bis_pkg::KIND_REQUEST) && mem_ok;
    assign t_load    = mem_rd && (r_k == 2'd3);
    assign p3_done   = mem_we || t_load;
    assign p3_ready  = !r_p3_vld || p3_done;
    assign p2_ready  = !r_p2_vld || p3_ready;
    assign p1_ready  = !r_p1_vld || p2_ready;

    assign o_in_stall = !p1_ready;
    assign in_acc     = i_in_valid && p1_ready;

    // Stage 1: range check, frame base, position products
    always_comb begin
        if (i_in_data.kind == bis_pkg::KIND_LOAD) begin
            in_ok = (32'(i_in_data.frame) < bis_pkg::FRAMES) &&
                    (32'(i_in_data.source_address) < bis_pkg::FRAME_SIZE);
        end else begin
            in_ok = (32'(i_in_data.frame) < bis_pkg::FRAMES) &&
                    (32'(i_in_data.dest_row) < bis_pkg::DST_MAX) &&
                    (32'(i_in_data.dest_column) < bis_pkg::DST_MAX);
        end
        n_p1.kind  = i_in_data.kind;
        n_p1.pixel = i_in_data.source_pixel;
        n_p1.addr  = bis_pkg::ADDR_W'(i_in_data.frame) * bis_pkg::ADDR_W'(bis_pkg::FRAME_SIZE);
        if (i_in_data.kind == bis_pkg::KIND_LOAD) begin
            n_p1.addr = n_p1.addr + bis_pkg::ADDR_W'(i_in_data.source_address);
        end
        n_p1.out_row    = bis_pkg::OUTC_W'(i_in_data.dest_row) + bis_pkg::OUTC_W'(1);
        n_p1.out_column = bis_pkg::OUTC_W'(i_in_data.dest_column) + bis_pkg::OUTC_W'(1);
        n_p1.prod_r = bis_pkg::POS_W'(i_in_data.dest_row) * bis_pkg::POS_W'(r_row_step);
        n_p1.prod_c = bis_pkg::POS_W'(i_in_data.dest_column) * bis_pkg::POS_W'(r_col_step);
    end

    // Stage 2: clamp positions, neighbor indices and fractions
    always_comb begin
        if (r_cfg_height == '0) begin
            h_used = bis_pkg::HDIM_W'(1);
        end else if (32'(r_cfg_height) > bis_pkg::SRC_MAX_HEIGHT) begin
            h_used = bis_pkg::HDIM_W'(bis_pkg::SRC_MAX_HEIGHT);
        end else begin
            h_used = bis_pkg::HDIM_W'(r_cfg_height);
        end
        if (r_cfg_width == '0) begin
            w_used = bis_pkg::WDIM_W'(1);
        end else if (32'(r_cfg_width) > bis_pkg::SRC_MAX_WIDTH) begin
            w_used = bis_pkg::WDIM_W'(bis_pkg::SRC_MAX_WIDTH);
        end else begin
            w_used = bis_pkg::WDIM_W'(r_cfg_width);
        end
        h_last = h_used - bis_pkg::HDIM_W'(1);
        w_last = w_used - bis_pkg::WDIM_W'(1);
        lim_r  = bis_pkg::POS_W'(h_last) << bis_pkg::FRAC_W;
        lim_c  = bis_pkg::POS_W'(w_last) << bis_pkg::FRAC_W;
        pos_r  = (r_p1.prod_r > lim_r) ? lim_r : r_p1.prod_r;
        pos_c  = (r_p1.prod_c > lim_c) ? lim_c : r_p1.prod_c;

        n_p2.kind       = r_p1.kind;
        n_p2.addr       = r_p1.addr;
        n_p2.pixel      = r_p1.pixel;
        n_p2.out_row    = r_p1.out_row;
        n_p2.out_column = r_p1.out_column;
        n_p2.r0 = pos_r[bis_pkg::FRAC_W +: bis_pkg::ROW_W];
        n_p2.c0 = pos_c[bis_pkg::FRAC_W +: bis_pkg::COL_W];
        n_p2.fv = pos_r[bis_pkg::FRAC_W-1 -: bis_pkg::WGT_W];
        n_p2.fu = pos_c[bis_pkg::FRAC_W-1 -: bis_pkg::WGT_W];
        r0_inc  = {1'b0, n_p2.r0} + (bis_pkg::ROW_W + 1)'(1);
        c0_inc  = {1'b0, n_p2.c0} + (bis_pkg::COL_W + 1)'(1);
        n_p2.r1 = (r0_inc < (bis_pkg::ROW_W + 1)'(h_used)) ?
                  r0_inc[bis_pkg::ROW_W-1:0] : bis_pkg::ROW_W'(h_last);
        n_p2.c1 = (c0_inc < (bis_pkg::COL_W + 1)'(w_used)) ?
                  c0_inc[bis_pkg::COL_W-1:0] : bis_pkg::COL_W'(w_last);
    end

    // Stage 3: frame memory port, at most one access per cycle
    always_comb begin
        rd_row   = r_k[1] ? r_p3.r1 : r_p3.r0;
        rd_col   = r_k[0] ? r_p3.c1 : r_p3.c0;
        mem_addr = r_p3.addr;
        if (r_p3.kind == bis_pkg::KIND_REQUEST) begin
            mem_addr = r_p3.addr
                     + bis_pkg::ADDR_W'(rd_row) * bis_pkg::ADDR_W'(bis_pkg::SRC_MAX_WIDTH)
                     + bis_pkg::ADDR_W'(rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= r_p3.pixel;
        end
        if (mem_rd) begin
            r_mem_q <= r_store[mem_addr];
        end
    end

    // Stage 4: horizontal interpolation of the top and bottom neighbor pairs
    always_comb begin
        n_m1.out_row    = r_t.out_row;
        n_m1.out_column = r_t.out_column;
        n_m1.fv         = r_t.fv;
        for (int i = 0; i < 3; i++) begin
            n_m1.top[i] = lerp_h(r_t.fu, widen(r_t.px0, i), widen(r_t.px1, i));
            n_m1.bot[i] = lerp_h(r_t.fu, widen(r_t.px2, i), widen(r_mem_q, i));
        end
    end

    always_comb begin
        n_out.out_row    = r_m1.out_row;
        n_out.out_column = r_m1.out_column;
        n_out.red   = lerp_v(r_m1.fv, r_m1.top[bis_pkg::CH_RED], r_m1.bot[bis_pkg::CH_RED]);
        n_out.green = lerp_v(r_m1.fv, r_m1.top[bis_pkg::CH_GREEN],
                             r_m1.bot[bis_pkg::CH_GREEN]);
        n_out.blue  = lerp_v(r_m1.fv, r_m1.top[bis_pkg::CH_BLUE], r_m1.bot[bis_pkg::CH_BLUE]);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_k       <= 2'd0;
            r_t_vld   <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (p1_ready) begin
                r_p1_vld <= in_acc && in_ok;
            end
            if (p2_ready) begin
                r_p2_vld <= r_p1_vld;
            end
            if (p3_ready) begin
                r_p3_vld <= r_p2_vld;
            end
            if (mem_rd) begin
                r_k <= r_k + 2'd1;
            end
            r_t_vld <= t_load || (r_t_vld && !t_go);
            if (m1_ready) begin
                r_m1_vld <= r_t_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_m1_vld;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (p1_ready) begin
            r_p1 <= n_p1;
        end
        if (p2_ready) begin
            r_p2 <= n_p2;
        end
        if (p3_ready) begin
            r_p3 <= r_p2;
        end
        if (mem_rd && (r_k == 2'd1)) begin
            r_px0 <= r_mem_q;
        end
        if (mem_rd && (r_k == 2'd2)) begin
            r_px1 <= r_mem_q;
        end
        if (t_load) begin
            r_t.out_row    <= r_p3.out_row;
            r_t.out_column <= r_p3.out_column;
            r_t.fv         <= r_p3.fv;
            r_t.fu         <= r_p3.fu;
            r_t.px0        <= r_px0;
            r_t.px1        <= r_px1;
            r_t.px2        <= r_mem_q;
        end
        if (m1_ready) begin
            r_m1 <= n_m1;
        end
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_rd_keeps_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_rd && r_t_vld) |-> t_go)
        else $error("read issued while the last neighbor is still waiting");

    a_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_rd))
        else $error("frame memory written and read in one cycle");

    a_seq_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 2'd0) |-> (r_p3_vld && (r_p3.kind == bis_pkg::KIND_REQUEST)))
        else $error("neighbor sequence active without a request");

    a_last_to_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_load |=> r_t_vld)
        else $error("fourth read did not fill the tail stage");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t_vld && !t_go) |=> (r_t_vld && $stable(r_t) && $stable(r_mem_q)))
        else $error("waiting neighbor set changed");

endmodule

>>> verif/tb_bilinear_image_scaler.sv
// Testbench for the bilinear image scaler: scoreboard class, stimulus tasks and result checks.
`timescale 1ns / 1ps

module tb_bilinear_image_scaler;

    class scaler_scoreboard;
        logic [bis_pkg::PIX_W-1:0]   pixel_store [bis_pkg::STORE_SIZE];
        bit                          loaded [bis_pkg::STORE_SIZE];
        logic [bis_pkg::CFG_H_W-1:0] src_height;
        logic [bis_pkg::CFG_W_W-1:0] src_width;
        logic [bis_pkg::STEP_W-1:0]  row_step;
        logic [bis_pkg::STEP_W-1:0]  col_step;
        bis_pkg::t_out_item          pending [$];
        int unsigned                 errors;
        int unsigned                 loads_seen;
        int unsigned                 loads_dropped;
        int unsigned                 requests_seen;
        int unsigned                 results_checked;
        int unsigned                 reg_writes;

        function new();
            src_height = bis_pkg::RST_SOURCE_HEIGHT;
            src_width  = bis_pkg::RST_SOURCE_WIDTH;
            row_step   = bis_pkg::RST_ROW_STEP;
            col_step   = bis_pkg::RST_COLUMN_STEP;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(input logic [bis_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bis_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bis_pkg::REG_SOURCE_HEIGHT: src_height = data[bis_pkg::CFG_H_W-1:0];
                bis_pkg::REG_SOURCE_WIDTH:  src_width  = data[bis_pkg::CFG_W_W-1:0];
                bis_pkg::REG_ROW_STEP:      row_step   = data[bis_pkg::STEP_W-1:0];
                bis_pkg::REG_COLUMN_STEP:   col_step   = data[bis_pkg::STEP_W-1:0];
                default: ;
            endcase
            reg_writes++;
        endfunction

        function int unsigned used_rows();
            if (src_height == 0) return 1;
            if (src_height > bis_pkg::SRC_MAX_HEIGHT) return bis_pkg::SRC_MAX_HEIGHT;
            return src_height;
        endfunction

        function int unsigned used_cols();
            if (src_width == 0) return 1;
            if (src_width > bis_pkg::SRC_MAX_WIDTH) return bis_pkg::SRC_MAX_WIDTH;
            return src_width;
        endfunction

        function void locate(input logic [bis_pkg::DEST_W-1:0] dest,
                             input logic [bis_pkg::STEP_W-1:0] step,
                             input int unsigned used, output int unsigned base,
                             output int unsigned next,
                             output logic [bis_pkg::WGT_W-1:0] frac);
            longint unsigned pos;
            longint unsigned lim;
            pos = longint'(dest) * longint'(step);
            lim = longint'(used - 1) << bis_pkg::FRAC_W;
            if (pos > lim) pos = lim;
            base = 32'(pos >> bis_pkg::FRAC_W);
            frac = pos[bis_pkg::FRAC_W-1:bis_pkg::FRAC_W-bis_pkg::WGT_W];
            next = (base + 1 < used) ? base + 1 : used - 1;
        endfunction

        function void neighbors(input logic [bis_pkg::DEST_W-1:0] drow,
                                input logic [bis_pkg::DEST_W-1:0] dcol,
                                output int unsigned raster [4],
                                output logic [bis_pkg::WGT_W-1:0] fv,
                                output logic [bis_pkg::WGT_W-1:0] fu);
            int unsigned r0, r1, c0, c1;
            locate(drow, row_step, used_rows(), r0, r1, fv);
            locate(dcol, col_step, used_cols(), c0, c1, fu);
            raster[0] = r0 * bis_pkg::SRC_MAX_WIDTH + c0;
            raster[1] = r0 * bis_pkg::SRC_MAX_WIDTH + c1;
            raster[2] = r1 * bis_pkg::SRC_MAX_WIDTH + c0;
            raster[3] = r1 * bis_pkg::SRC_MAX_WIDTH + c1;
        endfunction

        function longint unsigned channel(input logic [bis_pkg::PIX_W-1:0] px, input int ch);
            case (ch)
                bis_pkg::CH_RED:   return longint'(px[15:11]) << 5;
                bis_pkg::CH_GREEN: return longint'(px[10:5]) << 4;
                default:           return longint'(px[4:0]) << 5;
            endcase
        endfunction

        function void note_input(input bis_pkg::t_in_item it);
            int unsigned                 raster [4];
            int unsigned                 base;
            logic [bis_pkg::WGT_W-1:0]   fv, fu;
            logic [bis_pkg::PIX_W-1:0]   nb [4];
            longint unsigned             top, bot, sum, v;
            logic [bis_pkg::CH_W-1:0]    res [3];
            bis_pkg::t_out_item          exp;
            if (it.kind == bis_pkg::KIND_LOAD) begin
                if (it.source_address < bis_pkg::FRAME_SIZE && it.frame < bis_pkg::FRAMES) begin
                    pixel_store[it.frame * bis_pkg::FRAME_SIZE + it.source_address] =
                        it.source_pixel;
                    loaded[it.frame * bis_pkg::FRAME_SIZE + it.source_address] = 1'b1;
                    loads_seen++;
                end else begin
                    loads_dropped++;
                end
                return;
            end
            if (it.frame >= bis_pkg::FRAMES || it.dest_row >= bis_pkg::DST_MAX ||
                it.dest_column >= bis_pkg::DST_MAX)
                return;
            requests_seen++;
            base = it.frame * bis_pkg::FRAME_SIZE;
            neighbors(it.dest_row, it.dest_column, raster, fv, fu);
            for (int k = 0; k < 4; k++) nb[k] = pixel_store[base + raster[k]];
            for (int ch = 0; ch < 3; ch++) begin
                top = (256 - longint'(fu)) * channel(nb[0], ch) + longint'(fu) * channel(nb[1], ch);
                bot = (256 - longint'(fu)) * channel(nb[2], ch) + longint'(fu) * channel(nb[3], ch);
                sum = (256 - longint'(fv)) * top + longint'(fv) * bot;
                v = (sum + 32768) >> 16;
                res[ch] = (v > 1023) ? 10'd1023 : bis_pkg::CH_W'(v);
            end
            exp.out_row    = bis_pkg::OUTC_W'(it.dest_row) + 1'b1;
            exp.out_column = bis_pkg::OUTC_W'(it.dest_column) + 1'b1;
            exp.red        = res[bis_pkg::CH_RED];
            exp.green      = res[bis_pkg::CH_GREEN];
            exp.blue       = res[bis_pkg::CH_BLUE];
            pending.push_back(exp);
        endfunction

        task check_result(input bis_pkg::t_out_item got);
            bis_pkg::t_out_item exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d",
                                 got.out_row, got.out_column));
                return;
            end
            exp = pending.pop_front();
            results_checked++;
            if (got.out_row !== exp.out_row)
                report($sformatf("out_row %0d, want %0d", got.out_row, exp.out_row));
            if (got.out_column !== exp.out_column)
                report($sformatf("out_column %0d, want %0d", got.out_column, exp.out_column));
            if (got.red !== exp.red)
                report($sformatf("red %0d, want %0d at %0d,%0d", got.red, exp.red,
                                 exp.out_row, exp.out_column));
            if (got.green !== exp.green)
                report($sformatf("green %0d, want %0d at %0d,%0d", got.green, exp.green,
                                 exp.out_row, exp.out_column));
            if (got.blue !== exp.blue)
                report($sformatf("blue %0d, want %0d at %0d,%0d", got.blue, exp.blue,
                                 exp.out_row, exp.out_column));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    bis_pkg::t_in_item              i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    bis_pkg::t_out_item             o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data;

    scaler_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      stim_count;
    int unsigned      settings_used;

    bilinear_image_scaler DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        end
    end

    task automatic drive_item(input bis_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.kind == bis_pkg::KIND_REQUEST || it.source_address < bis_pkg::FRAME_SIZE)
            stim_count++;
        @(negedge i_clk);
    endtask

    task automatic load_pixel(input logic frame, input logic [bis_pkg::SADDR_W-1:0] addr,
                              input logic [bis_pkg::PIX_W-1:0] pixel);
        bis_pkg::t_in_item it;
        it.kind           = bis_pkg::KIND_LOAD;
        it.frame          = frame;
        it.source_address = addr;
        it.source_pixel   = pixel;
        it.dest_row       = bis_pkg::DEST_W'($urandom_range(0, bis_pkg::DST_MAX - 1));
        it.dest_column    = bis_pkg::DEST_W'($urandom_range(0, bis_pkg::DST_MAX - 1));
        drive_item(it);
    endtask

    // fill any neighbor that was never loaded before the request goes out
    task automatic request_pixel(input logic frame, input logic [bis_pkg::DEST_W-1:0] drow,
                                 input logic [bis_pkg::DEST_W-1:0] dcol);
        int unsigned               raster [4];
        logic [bis_pkg::WGT_W-1:0] fv, fu;
        bis_pkg::t_in_item         it;
        sb.neighbors(drow, dcol, raster, fv, fu);
        for (int k = 0; k < 4; k++) begin
            if (!sb.loaded[frame * bis_pkg::FRAME_SIZE + raster[k]])
                load_pixel(frame, bis_pkg::SADDR_W'(raster[k]),
                           bis_pkg::PIX_W'($urandom_range(0, 65535)));
        end
        it.kind           = bis_pkg::KIND_REQUEST;
        it.frame          = frame;
        it.source_address = bis_pkg::SADDR_W'($urandom_range(0, (1 << bis_pkg::SADDR_W) - 1));
        it.source_pixel   = bis_pkg::PIX_W'($urandom_range(0, 65535));
        it.dest_row       = drow;
        it.dest_column    = dcol;
        drive_item(it);
    endtask

    task automatic write_reg(input logic [bis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bis_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // hold off until every result is back, then let trailing loads settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic configure(input logic [bis_pkg::CFG_H_W-1:0] h,
                             input logic [bis_pkg::CFG_W_W-1:0] w,
                             input logic [bis_pkg::STEP_W-1:0] rs,
                             input logic [bis_pkg::STEP_W-1:0] cs);
        drain();
        write_reg(bis_pkg::REG_SOURCE_HEIGHT, bis_pkg::CFG_DATA_W'(h));
        write_reg(bis_pkg::REG_SOURCE_WIDTH, bis_pkg::CFG_DATA_W'(w));
        write_reg(bis_pkg::REG_ROW_STEP, rs);
        write_reg(bis_pkg::REG_COLUMN_STEP, cs);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [bis_pkg::STEP_W-1:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return bis_pkg::STEP_W'($urandom_range(0, 24'h03FFFF));
            1:       return bis_pkg::STEP_W'($urandom_range(0, 24'h00FFFF));
            2:       return bis_pkg::STEP_W'($urandom_range(0, 24'hFFFFFF));
            default: return bis_pkg::STEP_W'($urandom_range(0, 3) << bis_pkg::FRAC_W);
        endcase
    endfunction

    task automatic random_set(input int unsigned n);
        logic [bis_pkg::CFG_H_W-1:0] h;
        logic [bis_pkg::CFG_W_W-1:0] w;
        int unsigned                 rows, cols, target, roll;
        logic [bis_pkg::DEST_W-1:0]  drow, dcol;
        if ($urandom_range(0, 3) == 0) begin
            h = bis_pkg::CFG_H_W'($urandom_range(0, 255));
            w = bis_pkg::CFG_W_W'($urandom_range(0, 511));
        end else begin
            h = bis_pkg::CFG_H_W'($urandom_range(0, 8));
            w = bis_pkg::CFG_W_W'($urandom_range(0, 8));
        end
        configure(h, w, pick_step(), pick_step());
        rows   = sb.used_rows();
        cols   = sb.used_cols();
        target = stim_count + n;
        while (stim_count < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                if ($urandom_range(0, 1) == 0) begin
                    drow = bis_pkg::DEST_W'($urandom_range(0, 15));
                    dcol = bis_pkg::DEST_W'($urandom_range(0, 15));
                end else begin
                    drow = bis_pkg::DEST_W'($urandom_range(0, bis_pkg::DST_MAX - 1));
                    dcol = bis_pkg::DEST_W'($urandom_range(0, bis_pkg::DST_MAX - 1));
                end
                request_pixel(1'($urandom_range(0, bis_pkg::FRAMES - 1)), drow, dcol);
            end else if (roll < 90) begin
                load_pixel(1'($urandom_range(0, bis_pkg::FRAMES - 1)),
                           bis_pkg::SADDR_W'($urandom_range(0, rows - 1) * bis_pkg::SRC_MAX_WIDTH
                                             + $urandom_range(0, cols - 1)),
                           bis_pkg::PIX_W'($urandom_range(0, 65535)));
            end else begin
                load_pixel(1'($urandom_range(0, 1)),
                           bis_pkg::SADDR_W'($urandom_range(0, (1 << bis_pkg::SADDR_W) - 1)),
                           bis_pkg::PIX_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stim_count    = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of size and step, pure colors, frame edges, dropped loads
        configure(8'd240, 9'd320, 24'd0, 24'hFFFFFF);
        load_pixel(1'b0, 17'd0, 16'hFFFF);
        load_pixel(1'b0, 17'd1, 16'h0000);
        load_pixel(1'b0, bis_pkg::SADDR_W'(bis_pkg::SRC_MAX_WIDTH), 16'hF800);
        load_pixel(1'b0, bis_pkg::SADDR_W'(bis_pkg::SRC_MAX_WIDTH + 1), 16'h07E0);
        request_pixel(1'b0, 9'd0, 9'd0);
        request_pixel(1'b0, 9'd511, 9'd511);
        load_pixel(1'b1, bis_pkg::SADDR_W'(bis_pkg::FRAME_SIZE - 1), 16'h001F);
        load_pixel(1'b0, bis_pkg::SADDR_W'(bis_pkg::FRAME_SIZE), 16'hAAAA);
        load_pixel(1'b1, 17'h1FFFF, 16'h5555);
        request_pixel(1'b1, 9'd0, 9'd511);
        configure(8'd0, 9'd0, 24'hFFFFFF, 24'hFFFFFF);
        request_pixel(1'b0, 9'd511, 9'd0);
        request_pixel(1'b1, 9'd0, 9'd511);
        // a half-way sum on green must round up
        configure(8'd255, 9'd511, 24'h008000, 24'h000100);
        load_pixel(1'b0, 17'd0, 16'h0000);
        load_pixel(1'b0, 17'd1, 16'h0100);
        request_pixel(1'b0, 9'd0, 9'd1);
        request_pixel(1'b0, 9'd1, 9'd1);

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin send_idle_pct = 9;  recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 9;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int set = 0; set < 3; set++) random_set(150);
        end

        drain();
        $display("covered %0d loads (%0d dropped), %0d requests, %0d results checked",
                 sb.loads_seen, sb.loads_dropped, sb.requests_seen, sb.results_checked);
        $display("%0d register writes over %0d settings, three idle mixes",
                 sb.reg_writes, settings_used);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
